### rtl/tracer_forcing_positivity_column_unit_macros.svh
// Assertion macros for the tracer forcing column unit.
// Used at the end of the top level; expects clk and rst in scope.
`ifndef TRACER_FORCING_POSITIVITY_COLUMN_UNIT_MACROS_SVH
`define TRACER_FORCING_POSITIVITY_COLUMN_UNIT_MACROS_SVH

// same-cycle implication
`define TFPC_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define TFPC_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/tfpc_pkg.sv
// Shared types, widths and constants of the tracer forcing column unit.
// No dependencies; every module imports it.
package tfpc_pkg;

  localparam int DEFAULT_LEVELS      = 64;
  localparam int DEFAULT_MAX_TRACERS = 64;

  localparam int MW  = 48;  // mass, rate, ratio
  localparam int PW  = 47;  // pressures, time step
  localparam int CW  = 31;  // hybrid coefficients
  localparam int IW  = 6;   // tracer and level numbers
  localparam int DPW = 49;  // layer thickness
  localparam int SW  = 56;  // increment sum
  localparam int RIW = 2;   // register index

  localparam logic [PW-1:0] TIME_STEP_RESET    = 47'd16777216;
  localparam logic [PW-1:0] REF_PRESSURE_RESET = 47'd1677721600000;

  localparam logic [MW-1:0] MASS_MAX = {1'b0, {(MW-1){1'b1}}};
  localparam logic [MW-1:0] MASS_MIN = {1'b1, {(MW-1){1'b0}}};
  localparam logic [PW-1:0] PRESS_MAX = {PW{1'b1}};

  typedef enum logic [RIW-1:0] {
    REG_TIME_STEP    = 2'd0,
    REG_REF_PRESSURE = 2'd1,
    REG_MOIST_MODE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DIRECT = 2'd1,
    OP_BUF    = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INC, S_CLIP, S_MOIST, S_RD, S_LOAD, S_TA_GO, S_TA_WAIT,
    S_TB_GO, S_TB_WAIT, S_CHK, S_DIV, S_EMIT
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [IW-1:0]        tracer;
    logic [IW-1:0]        level;
    logic                 last;
    logic signed [MW-1:0] mass;
    logic signed [MW-1:0] rate;
    logic [PW-1:0]        ps;
    logic [CW-1:0]        a;
    logic [CW-1:0]        b;
  } cmd_t;

  typedef struct packed {
    logic          start;
    logic [MW-1:0] x;
    logic [MW-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [2*MW-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic           start;
    logic [MW-1:0]  m;
    logic [DPW-1:0] dp;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [MW-1:0] q;
  } div_rsp_t;

endpackage

### rtl/tfpc_front.sv
// Front end: accepts input beats, classifies them and queues commands.
// Depends on tfpc_pkg.
module tfpc_front import tfpc_pkg::*; #(
  parameter int LEVELS      = DEFAULT_LEVELS,
  parameter int MAX_TRACERS = DEFAULT_MAX_TRACERS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 kind,
  input  logic [IW-1:0]        tracer_index,
  input  logic [IW-1:0]        level_index,
  input  logic                 last_level,
  input  logic signed [MW-1:0] tracer_mass,
  input  logic signed [MW-1:0] forcing_rate,
  input  logic [PW-1:0]        surface_pressure_in,
  input  logic [CW-1:0]        a_delta,
  input  logic [CW-1:0]        b_delta,
  output cmd_t                 head,
  output logic                 head_valid,
  input  logic                 take
);

  cmd_t       slot [2];
  cmd_t       in_cmd;
  logic [1:0] cnt;
  logic       wr_ptr, rd_ptr;
  logic       in_range, we;

  assign full       = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head       = slot[rd_ptr];

  always_comb begin
    in_range = ({1'b0, level_index} < (IW+1)'(LEVELS)) &&
               ({1'b0, tracer_index} < (IW+1)'(MAX_TRACERS));
    // drop level beats outside the configured column
    we = push && !full && (!kind || in_range);
    in_cmd.op     = !kind ? OP_START : ((tracer_index == '0) ? OP_BUF : OP_DIRECT);
    in_cmd.tracer = tracer_index;
    in_cmd.level  = level_index;
    in_cmd.last   = last_level;
    in_cmd.mass   = tracer_mass;
    in_cmd.rate   = forcing_rate;
    in_cmd.ps     = surface_pressure_in;
    in_cmd.a      = a_delta;
    in_cmd.b      = b_delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (we) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, we} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (we) slot[wr_ptr] <= in_cmd;
  end

endmodule

### rtl/tfpc_mul.sv
// Shift-add multiplier, one bit of x per cycle.
// Depends on tfpc_pkg.
module tfpc_mul import tfpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [2*MW-1:0] acc;
  logic [MW-1:0]   xs, ys;
  logic [5:0]      cnt;
  logic            busy, done;
  logic [MW:0]     step;

  assign step = {1'b0, acc[2*MW-1:MW]} + (xs[0] ? {1'b0, ys} : '0);

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 6'(MW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      xs  <= req.x;
      ys  <= req.y;
    end else if (busy) begin
      acc <= {step, acc[MW-1:1]};
      xs  <= xs >> 1;
    end
  end

endmodule

### rtl/tfpc_div.sv
// Restoring divider: (m << 24) / dp, one quotient bit per cycle.
// Depends on tfpc_pkg; the caller screens out overflow and zero divisors.
module tfpc_div import tfpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NW = MW + 24;

  logic [NW-1:0]  num;
  logic [DPW-1:0] dp, rem;
  logic [MW-1:0]  q;
  logic [6:0]     cnt;
  logic           busy, done;
  logic [DPW:0]   r2;
  logic           ge;

  always_comb begin
    r2 = {rem, num[NW-1]};
    ge = (r2 >= {1'b0, dp});
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.q    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 7'(NW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= {req.m, 24'd0};
      dp  <= req.dp;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      num <= num << 1;
      rem <= ge ? DPW'(r2 - {1'b0, dp}) : r2[DPW-1:0];
      q   <= {q[MW-2:0], ge};
    end
  end

endmodule

### rtl/tfpc_back.sv
// Back end: sequencer for forcing, tracer 0 buffering, thickness and ratio.
// Depends on tfpc_pkg; drives the shared multiplier and the divider.
module tfpc_back import tfpc_pkg::*; #(
  parameter int LEVELS = DEFAULT_LEVELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PW-1:0]        time_step,
  input  logic [PW-1:0]        reference_pressure,
  input  logic                 moist_mode,
  input  cmd_t                 head,
  input  logic                 head_valid,
  output logic                 take,
  output mul_req_t             mul_req,
  input  mul_rsp_t             mul_rsp,
  output div_req_t             div_req,
  input  div_rsp_t             div_rsp,
  input  logic                 pop,
  output logic                 empty,
  output logic [IW-1:0]        out_tracer,
  output logic [IW-1:0]        out_level,
  output logic signed [MW-1:0] new_mass,
  output logic signed [MW-1:0] mixing_ratio,
  output logic [PW-1:0]        new_surface_pressure,
  output logic                 last_result
);

  localparam int CNTW = $clog2(LEVELS + 1);
  localparam int AW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  state_t state, state_next;

  // control
  logic [CNTW-1:0]      count, idx;
  logic signed [SW-1:0] inc_sum;
  logic [PW-1:0]        column_pressure;
  logic                 out_valid;

  // payload
  cmd_t                 cur;
  logic signed [MW:0]   inc_r;
  logic signed [MW-1:0] nm_r, ratio_r;
  logic [CW-1:0]        a_use, b_use;
  logic [PW-1:0]        ps_use;
  logic [IW-1:0]        tr_r, lv_r;
  logic                 last_r;
  logic [77:0]          prod_a;
  logic [DPW-1:0]       dp;

  logic signed [MW-1:0] mem_m [LEVELS];
  logic [CW-1:0]        mem_a [LEVELS];
  logic [CW-1:0]        mem_b [LEVELS];
  logic signed [MW-1:0] rd_m;
  logic [CW-1:0]        rd_a, rd_b;

  logic                 out_free, mem_we, flushing, need_div;
  logic [MW-1:0]        rate_abs, lim, mag, m_abs;
  logic [71:0]          p;
  logic signed [MW:0]   inc_sat, inc_f;
  logic signed [MW+1:0] s50;
  logic signed [MW-1:0] nm_val, sat_val;
  logic signed [SW:0]   sum_wide;
  logic signed [SW-1:0] sum_sat;
  logic signed [SW+1:0] cp_wide;
  logic [PW-1:0]        cp_sat;
  logic [78:0]          dp_sum;

  assign out_free = !out_valid || pop;
  assign flushing = (cur.op == OP_BUF);
  assign empty    = !out_valid;

  // arithmetic
  always_comb begin
    rate_abs = head.rate[MW-1] ? (~head.rate + 1'b1) : head.rate;

    p   = mul_rsp.prod[2*MW-1:24];
    lim = cur.rate[MW-1] ? MASS_MIN : MASS_MAX;
    mag = (p > 72'(lim)) ? lim : p[MW-1:0];
    inc_sat = cur.rate[MW-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    s50 = (MW+2)'(cur.mass) + (MW+2)'(inc_r);
    if (cur.rate[MW-1] && s50[MW+1]) begin
      // clip so the mass does not cross zero
      inc_f  = cur.mass[MW-1] ? '0 : -((MW+1)'(cur.mass));
      nm_val = cur.mass[MW-1] ? cur.mass : '0;
    end else begin
      inc_f = inc_r;
      if (s50[MW+1:MW-1] == 3'b000 || s50[MW+1:MW-1] == 3'b111) begin
        nm_val = s50[MW-1:0];
      end else begin
        nm_val = s50[MW+1] ? MASS_MIN : MASS_MAX;
      end
    end

    sum_wide = (SW+1)'(inc_sum) + (SW+1)'(inc_f);
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end

    cp_wide = $signed({{(SW+1-PW){1'b0}}, column_pressure}) + (SW+2)'(inc_sum);
    if (cp_wide[SW+1]) begin
      cp_sat = '0;
    end else if (cp_wide[SW:PW] != '0) begin
      cp_sat = PRESS_MAX;
    end else begin
      cp_sat = cp_wide[PW-1:0];
    end

    dp_sum = {1'b0, prod_a} + {1'b0, mul_rsp.prod[77:0]};

    m_abs    = nm_r[MW-1] ? (~nm_r + 1'b1) : nm_r;
    sat_val  = nm_r[MW-1] ? MASS_MIN : MASS_MAX;
    need_div = (nm_r != '0) && (dp != '0) &&
               ({24'd0, m_abs} < {dp, 23'd0});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head_valid && head.op != OP_START) state_next = S_INC;
      end
      S_INC:     if (mul_rsp.done) state_next = S_CLIP;
      S_CLIP: begin
        if (cur.op == OP_DIRECT) state_next = S_TA_GO;
        else if (cur.last) state_next = S_MOIST;
        else state_next = S_IDLE;
      end
      S_MOIST:   state_next = (count == '0) ? S_IDLE : S_RD;
      S_RD:      state_next = S_LOAD;
      S_LOAD:    state_next = S_TA_GO;
      S_TA_GO:   state_next = S_TA_WAIT;
      S_TA_WAIT: if (mul_rsp.done) state_next = S_TB_GO;
      S_TB_GO:   state_next = S_TB_WAIT;
      S_TB_WAIT: if (mul_rsp.done) state_next = S_CHK;
      S_CHK:     state_next = need_div ? S_DIV : S_EMIT;
      S_DIV:     if (div_rsp.done) state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) state_next = (flushing && !last_r) ? S_RD : S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    take          = 1'b0;
    mul_req.start = 1'b0;
    mul_req.x     = rate_abs;
    mul_req.y     = {1'b0, time_step};
    div_req.start = 1'b0;
    div_req.m     = m_abs;
    div_req.dp    = dp;
    mem_we        = 1'b0;
    unique case (state)
      S_IDLE: begin
        take          = head_valid;
        mul_req.start = head_valid && (head.op != OP_START);
      end
      S_CLIP:  mem_we = flushing && (count < CNTW'(LEVELS));
      S_TA_GO: begin
        mul_req.start = 1'b1;
        mul_req.x     = {{(MW-CW){1'b0}}, a_use};
        mul_req.y     = {1'b0, reference_pressure};
      end
      S_TB_GO: begin
        mul_req.start = 1'b1;
        mul_req.x     = {{(MW-CW){1'b0}}, b_use};
        mul_req.y     = {1'b0, ps_use};
      end
      S_CHK:   div_req.start = need_div;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      idx             <= '0;
      inc_sum         <= '0;
      column_pressure <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && take && head.op == OP_START) begin
        column_pressure <= head.ps;
        inc_sum         <= '0;
        count           <= '0;
      end
      if (mem_we) begin
        count   <= count + CNTW'(1);
        inc_sum <= sum_sat;
      end
      if (state == S_MOIST) begin
        if (moist_mode) column_pressure <= cp_sat;
        idx <= '0;
        if (count == '0) inc_sum <= '0;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
        if (flushing) begin
          if (last_r) begin
            count   <= '0;
            inc_sum <= '0;
          end else begin
            idx <= idx + CNTW'(1);
          end
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= head;
    if (state == S_INC && mul_rsp.done) inc_r <= inc_sat;
    if (state == S_CLIP) begin
      nm_r   <= nm_val;
      a_use  <= cur.a;
      b_use  <= cur.b;
      ps_use <= column_pressure;
      tr_r   <= cur.tracer;
      lv_r   <= cur.level;
      last_r <= 1'b1;
    end
    if (state == S_LOAD) begin
      nm_r   <= rd_m;
      a_use  <= rd_a;
      b_use  <= rd_b;
      ps_use <= column_pressure;
      tr_r   <= '0;
      lv_r   <= IW'(idx);
      last_r <= ((idx + CNTW'(1)) == count);
    end
    if (state == S_TA_WAIT && mul_rsp.done) prod_a <= mul_rsp.prod[77:0];
    if (state == S_TB_WAIT && mul_rsp.done) dp <= dp_sum[78:30];
    if (state == S_CHK) ratio_r <= (nm_r == '0) ? '0 : sat_val;
    if (state == S_DIV && div_rsp.done) begin
      ratio_r <= nm_r[MW-1] ? -$signed(div_rsp.q) : $signed(div_rsp.q);
    end
    if (state == S_EMIT && out_free) begin
      out_tracer           <= tr_r;
      out_level            <= lv_r;
      new_mass             <= nm_r;
      mixing_ratio         <= ratio_r;
      new_surface_pressure <= ps_use;
      last_result          <= last_r;
    end
  end

  // tracer 0 level buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_m[count[AW-1:0]] <= nm_val;
      mem_a[count[AW-1:0]] <= cur.a;
      mem_b[count[AW-1:0]] <= cur.b;
    end
    if (state == S_RD) begin
      rd_m <= mem_m[idx[AW-1:0]];
      rd_a <= mem_a[idx[AW-1:0]];
      rd_b <= mem_b[idx[AW-1:0]];
    end
  end

endmodule

### rtl/tracer_forcing_positivity_column_unit.sv
// Top level of the tracer forcing column unit: config registers and wiring.
// Depends on tfpc_pkg, tfpc_front, tfpc_back, tfpc_mul, tfpc_div and the macros header.
//
//   channel   handshake      direction  contents
//   input     push / full    in         kind, indexes, mass, rate, ps, a, b
//   result    empty / pop    out        tracer, level, mass, ratio, ps, last
//   config    cfg_write      in         cfg_index, cfg_data
//
// A level of tracer 1 and up needs dt*rate, two products for the thickness and,
// when needed, the divide, all on one shared shift-add multiplier and one
// divider. A tracer 0 level is buffered after dt*rate; its flush repeats the
// thickness and ratio steps for each buffered level. The two-entry front queue
// and the result register let input and output stall independently. Reset is
// synchronous and needs no clearing pass.
module tracer_forcing_positivity_column_unit import tfpc_pkg::*; #(
  parameter int LEVELS      = DEFAULT_LEVELS,
  parameter int MAX_TRACERS = DEFAULT_MAX_TRACERS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 kind,
  input  logic [IW-1:0]        tracer_index,
  input  logic [IW-1:0]        level_index,
  input  logic                 last_level,
  input  logic signed [MW-1:0] tracer_mass,
  input  logic signed [MW-1:0] forcing_rate,
  input  logic [PW-1:0]        surface_pressure_in,
  input  logic [CW-1:0]        a_delta,
  input  logic [CW-1:0]        b_delta,
  output logic                 empty,
  input  logic                 pop,
  output logic [IW-1:0]        out_tracer,
  output logic [IW-1:0]        out_level,
  output logic signed [MW-1:0] new_mass,
  output logic signed [MW-1:0] mixing_ratio,
  output logic [PW-1:0]        new_surface_pressure,
  output logic                 last_result,
  input  logic                 cfg_write,
  input  logic [RIW-1:0]       cfg_index,
  input  logic [PW-1:0]        cfg_data
);

`include "tracer_forcing_positivity_column_unit_macros.svh"

  logic [PW-1:0] time_step, reference_pressure;
  logic          moist_mode;
  cmd_t          head;
  logic          head_valid, take;
  mul_req_t      mul_req;
  mul_rsp_t      mul_rsp;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step          <= TIME_STEP_RESET;
      reference_pressure <= REF_PRESSURE_RESET;
      moist_mode         <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_STEP:    time_step          <= cfg_data;
        REG_REF_PRESSURE: reference_pressure <= cfg_data;
        REG_MOIST_MODE:   moist_mode         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tfpc_front #(.LEVELS(LEVELS), .MAX_TRACERS(MAX_TRACERS)) u_front (
    .clk, .rst, .push, .full, .kind, .tracer_index, .level_index, .last_level,
    .tracer_mass, .forcing_rate, .surface_pressure_in, .a_delta, .b_delta,
    .head, .head_valid, .take
  );

  tfpc_back #(.LEVELS(LEVELS)) u_back (
    .clk, .rst, .time_step, .reference_pressure, .moist_mode,
    .head, .head_valid, .take, .mul_req, .mul_rsp, .div_req, .div_rsp,
    .pop, .empty, .out_tracer, .out_level, .new_mass, .mixing_ratio,
    .new_surface_pressure, .last_result
  );

  tfpc_mul u_mul (.clk, .rst, .req(mul_req), .rsp(mul_rsp));

  tfpc_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  `TFPC_ASSERT_IMP(a_mul_free, mul_req.start, !mul_rsp.busy, "multiplier started while busy")
  `TFPC_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `TFPC_ASSERT_NXT(a_mul_runs, mul_req.start, mul_rsp.busy, "multiplier did not start")
  `TFPC_ASSERT_IMP(a_queue_head, full, head_valid, "full queue shows no head")

endmodule

### bench/tracer_forcing_positivity_column_unit_test.sv
// Self-checking bench for the tracer forcing column unit: a directed table, then random columns.
// Depends on tfpc_pkg and tracer_forcing_positivity_column_unit; carries its own column predictor.
module tracer_forcing_positivity_column_unit_test;
  import tfpc_pkg::*;

  localparam longint ONE  = 64'sd1 << 24;
  localparam longint SMAX = (64'sd1 << 47) - 1;
  localparam longint SMIN = -(64'sd1 << 47);
  localparam longint A1   = 64'sd1 << 30;
  localparam longint IMAX = (64'sd1 << 55) - 1;

  typedef struct {
    bit     kind;
    int     tracer;
    int     level;
    bit     last;
    longint mass;
    longint rate;
    longint ps;
    longint a;
    longint b;
  } item_t;

  typedef struct {
    int     tracer;
    int     level;
    longint mass;
    longint ratio;
    longint ps;
    bit     last;
  } res_t;

  typedef struct {
    item_t  it;
    bit     typed;
    longint mass;
    longint ratio;
    longint ps;
  } row_t;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 push = 0;
  logic                 full;
  logic                 kind = 0;
  logic [IW-1:0]        tracer_index = '0;
  logic [IW-1:0]        level_index = '0;
  logic                 last_level = 0;
  logic signed [MW-1:0] tracer_mass = '0;
  logic signed [MW-1:0] forcing_rate = '0;
  logic [PW-1:0]        surface_pressure_in = '0;
  logic [CW-1:0]        a_delta = '0;
  logic [CW-1:0]        b_delta = '0;
  logic                 empty;
  logic                 pop = 0;
  logic [IW-1:0]        out_tracer;
  logic [IW-1:0]        out_level;
  logic signed [MW-1:0] new_mass;
  logic signed [MW-1:0] mixing_ratio;
  logic [PW-1:0]        new_surface_pressure;
  logic                 last_result;
  logic                 cfg_write = 0;
  reg_idx_t             cfg_index = REG_TIME_STEP;
  logic [PW-1:0]        cfg_data = '0;

  tracer_forcing_positivity_column_unit u_dut (.*);

  always #4 clk = ~clk;

  // predictor state
  longint dt_q, ps0_q, col_ps, inc_sum;
  bit     moist_q;
  longint buf_mass[64], buf_a[64], buf_b[64];
  int     buf_n;

  res_t   pending[$];
  int     errors;
  bit     no_idle;
  bit     hold_long;
  int     sent;

  function automatic longint sat48(longint v);
    return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
  endfunction

  function automatic longint forced_increment(longint mass, longint rate);
    logic [127:0] p;
    longint inc;
    p = (128'(rate < 0 ? -rate : rate) * 128'(dt_q)) >> 24;
    if (rate < 0) inc = (p > 128'(64'sd1 << 47)) ? SMIN : -longint'(p[63:0]);
    else inc = (p > 128'(SMAX)) ? SMAX : longint'(p[63:0]);
    if (rate < 0 && mass + inc < 0) inc = mass < 0 ? 0 : -mass;
    return inc;
  endfunction

  function automatic longint layer_thickness(longint a, longint b, longint ps);
    logic [127:0] s;
    s = (128'(a) * 128'(ps0_q) + 128'(b) * 128'(ps)) >> 30;
    return longint'(s[63:0]);
  endfunction

  function automatic longint mix_ratio(longint m, longint dp);
    logic [127:0] num, q;
    if (m == 0) return 0;
    if (dp == 0) return m > 0 ? SMAX : SMIN;
    num = 128'(m < 0 ? -m : m) << 24;
    if (num >= (128'(dp) << 47)) return m > 0 ? SMAX : SMIN;
    q = num / 128'(dp);
    return m > 0 ? longint'(q[63:0]) : -longint'(q[63:0]);
  endfunction

  task automatic predict_column(item_t it);
    longint inc, nm, p;
    res_t r;
    if (!it.kind) begin
      col_ps = it.ps;
      inc_sum = 0;
      buf_n = 0;
      return;
    end
    if (it.tracer != 0) begin
      inc = forced_increment(it.mass, it.rate);
      nm = sat48(it.mass + inc);
      r = '{it.tracer, it.level, nm,
            mix_ratio(nm, layer_thickness(it.a, it.b, col_ps)), col_ps, 1'b1};
      pending.push_back(r);
      return;
    end
    if (buf_n < 64) begin
      inc = forced_increment(it.mass, it.rate);
      nm = sat48(it.mass + inc);
      buf_mass[buf_n] = nm;
      buf_a[buf_n] = it.a;
      buf_b[buf_n] = it.b;
      buf_n++;
      p = inc_sum + inc;
      inc_sum = p > IMAX ? IMAX : (p < -IMAX - 1 ? -IMAX - 1 : p);
    end
    if (!it.last) return;
    if (moist_q) begin
      p = col_ps + inc_sum;
      col_ps = p < 0 ? 0 : (p > SMAX ? SMAX : p);
    end
    for (int i = 0; i < buf_n; i++) begin
      r = '{0, i, buf_mass[i],
            mix_ratio(buf_mass[i], layer_thickness(buf_a[i], buf_b[i], col_ps)),
            col_ps, i + 1 == buf_n};
      pending.push_back(r);
    end
    buf_n = 0;
    inc_sum = 0;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d (at %0t)", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send(item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      push <= 0;
    end
    @(negedge clk);
    push <= 1;
    kind <= it.kind;
    tracer_index <= IW'(it.tracer);
    level_index <= IW'(it.level);
    last_level <= it.last;
    tracer_mass <= MW'(it.mass);
    forcing_rate <= MW'(it.rate);
    surface_pressure_in <= PW'(it.ps);
    a_delta <= CW'(it.a);
    b_delta <= CW'(it.b);
    do @(posedge clk); while (full);
    predict_column(it);
    sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, longint val);
    @(negedge clk);
    push <= 0;
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val[PW-1:0];
    @(negedge clk);
    cfg_write <= 0;
    case (idx)
      REG_TIME_STEP:    dt_q = val;
      REG_REF_PRESSURE: ps0_q = val;
      default:          moist_q = val[0];
    endcase
  endtask

  // let the block settle: no result pending and trailing no-result items done
  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic longint rand_val();
    longint v;
    case ($urandom_range(0, 7))
      0: v = SMAX;
      1: v = SMIN;
      2: v = 0;
      3, 4: v = longint'($urandom_range(0, 200)) * ONE / 2 - 50 * ONE;
      default: v = {$urandom, $urandom};
    endcase
    return sat48(v <<< 16 >>> 16);
  endfunction

  function automatic longint rand_coef();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return A1;
      default: return $urandom_range(0, 1 << 30);
    endcase
  endfunction

  function automatic longint rand_ps();
    longint v;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return SMAX;
      2: begin
        v = {$urandom, $urandom};
        return v & SMAX;
      end
      default: return longint'($urandom_range(1, 200000)) * ONE;
    endcase
  endfunction

  function automatic item_t level_item(int tr, int lv, bit last);
    item_t it;
    it = '{1'b1, tr, lv, last, rand_val(), rand_val(), rand_ps(), rand_coef(), rand_coef()};
    return it;
  endfunction

  function automatic item_t start_item(longint ps);
    item_t it;
    it = '{1'b0, $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)),
           rand_val(), rand_val(), ps, rand_coef(), rand_coef()};
    return it;
  endfunction

  // one well-formed column, or now and then a broken one
  task automatic random_column();
    int n0, early;
    send(start_item(rand_ps()));
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send(level_item(0, $urandom_range(0, 63), 0));
      if ($urandom_range(0, 1)) send(level_item($urandom_range(1, 63), 0, 1));
      return;
    end
    n0 = $urandom_range(1, 6);
    early = $urandom_range(0, 2);
    for (int i = 0; i < n0; i++) begin
      if (i == 1) repeat (early) send(level_item($urandom_range(1, 63), $urandom_range(0, 63), 1));
      send(level_item(0, $urandom_range(0, 63), i == n0 - 1));
    end
    repeat ($urandom_range(0, 4))
      send(level_item($urandom_range(1, 63), $urandom_range(0, 63),
                      1'($urandom_range(0, 1))));
  endtask

  task automatic random_phase(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      no_idle = $urandom_range(0, 3) == 0;
      random_column();
    end
    no_idle = 0;
  endtask

  function automatic row_t mk(bit k, int tr, int lv, bit last, longint m, longint r,
                              longint ps, longint a, longint b, bit typed = 0,
                              longint em = 0, longint er = 0, longint eps = 0);
    row_t row;
    row.it = '{k, tr, lv, last, m, r, ps, a, b};
    row.typed = typed;
    row.mass = em;
    row.ratio = er;
    row.ps = eps;
    return row;
  endfunction

  // receiver
  initial begin
    int gap;
    res_t want;
    errors = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        gap = 1500;
        hold_long = 0;
      end else gap = no_idle ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        pop <= 0;
      end
      @(negedge clk);
      pop <= 1;
      do @(posedge clk); while (empty);
      if (pending.size() == 0) begin
        report("unexpected result beat, out_tracer", out_tracer, -1);
      end else begin
        want = pending.pop_front();
        if (out_tracer != want.tracer) report("out_tracer", out_tracer, want.tracer);
        if (out_level != want.level) report("out_level", out_level, want.level);
        if (longint'(new_mass) != want.mass) report("new_mass", new_mass, want.mass);
        if (longint'(mixing_ratio) != want.ratio)
          report("mixing_ratio", mixing_ratio, want.ratio);
        if (new_surface_pressure != want.ps)
          report("new_surface_pressure", new_surface_pressure, want.ps);
        if (last_result != want.last) report("last_result", last_result, want.last);
      end
    end
  end

  initial begin
    #8000000;
    $display("tracer_forcing_positivity_column_unit_test NOT OK");
    $finish;
  end

  initial begin
    row_t dir_tab[$];
    longint p;
    dt_q = ONE;
    ps0_q = 100000 * ONE;
    moist_q = 1;
    col_ps = 0;
    inc_sum = 0;
    buf_n = 0;
    no_idle = 0;
    hold_long = 0;
    sent = 0;
    p = 1000 * ONE;

    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, p, 0, 0));
    dir_tab.push_back(mk(1, 1, 0, 1, 0, 0, 0, 0, A1, 1, 0, 0, p));
    dir_tab.push_back(mk(1, 1, 1, 1, SMAX, SMAX, 0, 0, 0, 1, SMAX, SMAX, p));
    dir_tab.push_back(mk(1, 2, 2, 0, SMIN, SMIN, 0, 0, 0, 1, SMIN, SMIN, p));
    dir_tab.push_back(mk(1, 3, 3, 1, 5 * ONE, -10 * ONE, 0, A1, 0, 1, 0, 0, p));
    dir_tab.push_back(mk(1, 4, 4, 1, 2 * ONE, 0, 0, 0, A1, 1, 2 * ONE, 33554, p));
    dir_tab.push_back(mk(1, 63, 63, 1, ONE, ONE, SMAX, A1, 0, 1, 2 * ONE, 335, p));
    // tracer 0 buffered, another tracer slips in before the flush
    dir_tab.push_back(mk(1, 0, 5, 0, 3 * ONE, 2 * ONE, 0, A1, A1));
    dir_tab.push_back(mk(1, 0, 9, 0, -ONE, -ONE, 0, 12345, 1 << 29));
    dir_tab.push_back(mk(1, 7, 1, 1, 8 * ONE, -ONE, 0, A1, A1));
    dir_tab.push_back(mk(1, 0, 2, 1, 10 * ONE, 5 * ONE, 0, 0, A1));
    // start discards a partial tracer 0 run
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 50 * ONE, 0, 0));
    dir_tab.push_back(mk(1, 0, 0, 0, 4 * ONE, ONE, 0, A1, 0));
    dir_tab.push_back(mk(0, 5, 5, 1, SMAX, SMIN, 2 * ONE, A1, A1));
    dir_tab.push_back(mk(1, 0, 0, 1, 100 * ONE, -50 * ONE, 0, 0, 0));
    dir_tab.push_back(mk(1, 9, 3, 0, -3 * ONE, 7 * ONE, 0, A1, A1));
    // pressure saturates upward at the top of its range
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, SMAX, 0, 0));
    dir_tab.push_back(mk(1, 0, 1, 1, SMAX, SMAX, 0, A1, A1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (dir_tab[i]) begin
      send(dir_tab[i].it);
      if (dir_tab[i].typed) begin
        pending[$].mass = dir_tab[i].mass;
        pending[$].ratio = dir_tab[i].ratio;
        pending[$].ps = dir_tab[i].ps;
      end
    end
    random_phase(50);
    drain();

    write_reg(REG_TIME_STEP, SMAX);
    write_reg(REG_REF_PRESSURE, SMAX);
    write_reg(REG_MOIST_MODE, 0);
    random_phase(70);
    drain();

    write_reg(REG_TIME_STEP, 0);
    write_reg(REG_REF_PRESSURE, 0);
    write_reg(REG_MOIST_MODE, 1);
    random_phase(50);
    drain();

    write_reg(REG_TIME_STEP, longint'($urandom_range(0, 64)) * ONE / 8 + $urandom_range(0, 255));
    write_reg(REG_REF_PRESSURE, longint'($urandom_range(1, 200000)) * ONE);
    // overfull tracer 0 run: extra levels are dropped but the last still flushes
    send(start_item(1000 * ONE));
    for (int i = 0; i < 66; i++) send(level_item(0, i % 64, i == 65));
    // stall the output while the input keeps coming
    hold_long = 1;
    no_idle = 1;
    for (int i = 0; i < 8; i++) send(level_item(1 + i, i, 1));
    no_idle = 0;
    random_phase(40);
    drain();

    write_reg(REG_TIME_STEP, ONE / 2);
    write_reg(REG_REF_PRESSURE, 100000 * ONE);
    write_reg(REG_MOIST_MODE, 0);
    random_phase(70);

    @(negedge clk);
    push <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("tracer_forcing_positivity_column_unit_test OK");
    end else begin
      $display("tracer_forcing_positivity_column_unit_test NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tfpc_pkg.sv
rtl/tfpc_front.sv
rtl/tfpc_mul.sv
rtl/tfpc_div.sv
rtl/tfpc_back.sv
rtl/tracer_forcing_positivity_column_unit.sv
bench/tracer_forcing_positivity_column_unit_test.sv
